@@ rtl/core/dmp_pkg.sv @@
// ----------------------------------------------------------------------------
// DALI Manchester PHY package
// Shared types and constants for the bus PHY and its transmit queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmp_pkg;

  // Control from the PHY core to the transmit queue.
  typedef struct packed {
    logic push;
    logic pop;
  } dmp_qctl_t;

  // Length field of a queued frame.
  localparam int unsigned LenW = 5;

  // Command codes carried on tuser.
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_FORWARD  = 2'd1;
  localparam logic [1:0] FUNC_BACKWARD = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_STOP_RUN  = 3'd1;
  localparam logic [2:0] REG_IDLE_SEND = 3'd2;
  localparam logic [2:0] REG_REPEAT    = 3'd3;
  localparam logic [2:0] REG_BREAK     = 3'd4;
  localparam logic [2:0] REG_RECOVER   = 3'd5;
  localparam logic [2:0] REG_RETRIES   = 3'd6;

  // Send status codes.
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_SENT    = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  // Manchester timing, in ticks.
  localparam logic [7:0] HALF_MIN     = 8'd3;
  localparam logic [7:0] HALF_MAX     = 8'd5;
  localparam logic [7:0] FULL_MIN     = 8'd7;
  localparam logic [7:0] FULL_MAX     = 8'd9;
  localparam logic [7:0] LOW_LIMIT    = 8'd10;
  localparam logic [7:0] JITTER_BASE  = 8'd5;
  localparam logic [7:0] TX_OVERHEAD  = 8'd15;
  localparam logic [4:0] TX_MAX_LEN   = 5'd30;
  localparam logic [3:0] RETRY_SAT    = 4'd15;
  localparam logic [5:0] RX_COUNT_SAT = 6'd63;

  // Three-tap majority vote.
  localparam logic [7:0] MAJORITY3 = 8'b1110_1000;

endpackage

`default_nettype wire

@@ rtl/core/dmp_queue.sv @@
// ----------------------------------------------------------------------------
// DALI transmit queue
// Circular buffer of forward frames with a registered head read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmp_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned FRAME_BITS  = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  dmp_pkg::dmp_qctl_t                  ctl,
  input  wire  [FRAME_BITS-1:0]               wr_bits,
  input  wire  [dmp_pkg::LenW-1:0]            wr_len,
  output logic [FRAME_BITS-1:0]               rd_bits,
  output logic [dmp_pkg::LenW-1:0]            rd_len,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned EW = FRAME_BITS + dmp_pkg::LenW;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [EW-1:0] rd_word;

  assign head_next = ctl.pop ? ((head == LAST) ? '0 : head + 1'b1) : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctl.push) begin
        tail  <= (tail == LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The head entry is read ahead into rd_word; a write to it passes through.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= {wr_len, wr_bits};
    end
    if (ctl.push && (tail == head_next)) begin
      rd_word <= {wr_len, wr_bits};
    end else begin
      rd_word <= mem[head_next];
    end
  end

  assign rd_bits = rd_word[FRAME_BITS-1:0];
  assign rd_len  = rd_word[EW-1:FRAME_BITS];

endmodule

`default_nettype wire

@@ rtl/core/dali_manchester_phy_mac.sv @@
// ----------------------------------------------------------------------------
// DALI Manchester bus PHY
// Bus sampling, majority filter, Manchester receiver and transmitter.
// ----------------------------------------------------------------------------
// Usage: each input word on the s_axis channel is one step. tuser carries the
// command: a sample tick, a forward frame to queue, or a backward frame to
// start. A tick thresholds bus_sample, filters it, advances the receiver and
// the transmitter by one tick, and yields one result word on m_axis.
// Command words yield a result word too (drive level and queue_full only).
// Result words are registered: each shows on m_axis right after its input word.
// Throughput is one word per cycle unless stalled; each step is a single pass
// of logic from the input word and the state registers to the result register.
// When the receiver stalls, the result register holds its word and s_axis
// takes a new word in the same cycle that the held word is taken.
// Reset (synchronous, active high) returns the bus state to idle high, empties
// the transmit queue and loads the register defaults. No clearing pass is run.
// The user must write APB-style registers only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dali_manchester_phy_mac #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned FRAME_BITS  = 32
) (
  input  wire         clk,
  input  wire         rst,
  // Input words.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: bus_sample[11:0], jitter[19:12], frame_bits[51:20],
  // tx_length[56:52], watch_ticks[64:57], zero fill [71:65].
  input  wire  [71:0] s_axis_tdata,
  // tuser: func[1:0].
  input  wire  [1:0]  s_axis_tuser,
  // Result words.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: tx_drive[0], rx_ready[1], rx_frame[33:2], rx_length[39:34],
  // rx_valid[40], rx_repeat[41], send_status[43:42], queue_full[44],
  // zero fill [47:45].
  output logic [47:0] m_axis_tdata,
  // Configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [31:0] FMASK = 32'((64'd1 << FRAME_BITS) - 64'd1);

  // One-hot phase of the shared bus engine.
  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_RECEIVE = 6'b000010,
    M_INVALID = 6'b000100,
    M_WATCH   = 6'b001000,
    M_SEND    = 6'b010000,
    M_BREAK   = 6'b100000
  } mode_t;

  // Receiver working set, advanced once per half bit.
  typedef struct packed {
    logic [31:0] shift;
    logic [5:0]  count;
    logic        phase;
    logic        bad;
  } rx_t;

  // ---------------- configuration registers ----------------
  logic [11:0] level_threshold;
  logic [7:0]  stop_run_length;
  logic [7:0]  idle_before_send;
  logic [7:0]  repeat_window;
  logic [7:0]  break_ticks;
  logic [7:0]  recover_ticks;
  logic [3:0]  max_retries;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold  <= 12'd2048;
      stop_run_length  <= 8'd20;
      idle_before_send <= 8'd60;
      repeat_window    <= 8'd255;
      break_ticks      <= 8'd12;
      recover_ticks    <= 8'd40;
      max_retries      <= 4'd3;
    end else if (cfg_write && (paddr[1:0] == 2'b00)) begin
      unique case (cfg_index)
        dmp_pkg::REG_THRESHOLD: level_threshold  <= pwdata[11:0];
        dmp_pkg::REG_STOP_RUN:  stop_run_length  <= pwdata[7:0];
        dmp_pkg::REG_IDLE_SEND: idle_before_send <= pwdata[7:0];
        dmp_pkg::REG_REPEAT:    repeat_window    <= pwdata[7:0];
        dmp_pkg::REG_BREAK:     break_ticks      <= pwdata[7:0];
        dmp_pkg::REG_RECOVER:   recover_ticks    <= pwdata[7:0];
        dmp_pkg::REG_RETRIES:   max_retries      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      dmp_pkg::REG_THRESHOLD: prdata = {20'd0, level_threshold};
      dmp_pkg::REG_STOP_RUN:  prdata = {24'd0, stop_run_length};
      dmp_pkg::REG_IDLE_SEND: prdata = {24'd0, idle_before_send};
      dmp_pkg::REG_REPEAT:    prdata = {24'd0, repeat_window};
      dmp_pkg::REG_BREAK:     prdata = {24'd0, break_ticks};
      dmp_pkg::REG_RECOVER:   prdata = {24'd0, recover_ticks};
      dmp_pkg::REG_RETRIES:   prdata = {28'd0, max_retries};
      default:                prdata = '0;
    endcase
  end

  // ---------------- input word fields ----------------
  logic [1:0]  in_func;
  logic [11:0] in_sample;
  logic [7:0]  in_jitter;
  logic [31:0] in_bits;
  logic [4:0]  in_len;
  logic [7:0]  in_watch;
  logic        accept;

  assign in_func   = s_axis_tuser;
  assign in_sample = s_axis_tdata[11:0];
  assign in_jitter = s_axis_tdata[19:12];
  assign in_bits   = s_axis_tdata[51:20];
  assign in_len    = s_axis_tdata[56:52];
  assign in_watch  = s_axis_tdata[64:57];

  // The result register frees up in the same cycle that its word is taken.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------- state ----------------
  mode_t       mode;
  logic [2:0]  filter_history;
  logic        last_level;
  logic [7:0]  run_count;
  rx_t         rx;
  logic [37:0] prev_rx_frame;
  logic [7:0]  watch_count;
  logic [31:0] tx_shift;
  logic [7:0]  tx_ticks_left;
  logic [31:0] retry_bits;
  logic [4:0]  retry_len;
  logic        backward_flag;
  logic [7:0]  break_count;
  logic [3:0]  retry_count;
  logic        drive_level;

  // Queue interface.
  dmp_pkg::dmp_qctl_t          qctl;
  logic [FRAME_BITS-1:0]       q_bits;
  logic [dmp_pkg::LenW-1:0]    q_len;
  logic [CW-1:0]               q_count;
  logic                        q_full;
  logic                        q_nonempty;

  assign q_full     = (q_count >= CW'(QUEUE_DEPTH));
  assign q_nonempty = (q_count != '0);

  dmp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .wr_bits (in_bits[FRAME_BITS-1:0]),
    .wr_len  (in_len),
    .rd_bits (q_bits),
    .rd_len  (q_len),
    .count   (q_count)
  );

  // One received half bit: the first half carries the bit, the second must
  // be its complement.
  function automatic rx_t rx_half(input rx_t cur, input logic level,
                                  input logic [31:0] mask);
    rx_t r;
    r = cur;
    if (!cur.phase) begin
      r.shift = {cur.shift[30:0], ~level} & mask;
      if (cur.count < dmp_pkg::RX_COUNT_SAT) begin
        r.count = cur.count + 6'd1;
      end
    end else if (cur.shift[0] != level) begin
      r.bad = 1'b1;
    end
    r.phase = ~cur.phase;
    return r;
  endfunction

  // Transmit pattern: inverted data, first bit highest, start bit in bit 0
  // position order reversed so that the word is shifted out from the bottom.
  function automatic logic [31:0] tx_pattern(input logic [31:0] bits,
                                             input logic [4:0] len);
    logic [31:0] s;
    logic [4:0]  src;
    s = '0;
    for (int k = 1; k <= 30; k++) begin
      src = len - 5'(k);
      if (5'(k) <= len) begin
        s[k] = ~bits[src];
      end
    end
    return s;
  endfunction

  // ---------------- next state ----------------
  mode_t       mode_next;
  logic [2:0]  filter_history_next;
  logic        last_level_next;
  logic [7:0]  run_count_next;
  rx_t         rx_next;
  rx_t         rx_a;
  rx_t         rx_b;
  logic [37:0] prev_rx_frame_next;
  logic [7:0]  watch_count_next;
  logic [31:0] tx_shift_next;
  logic [7:0]  tx_ticks_left_next;
  logic [31:0] retry_bits_next;
  logic [4:0]  retry_len_next;
  logic        backward_flag_next;
  logic [7:0]  break_count_next;
  logic [3:0]  retry_count_next;
  logic        drive_level_next;

  logic        high;
  logic        filt;
  logic        ready;
  logic        valid;
  logic        repeat_hit;
  logic [1:0]  status;
  logic        qfull_flag;
  logic        start;
  logic [31:0] start_bits;
  logic [4:0]  start_len;
  logic [7:0]  start_watch;
  logic        start_back;
  logic [8:0]  jitter_sum;
  logic [7:0]  jitter_watch;
  logic        do_pop;

  assign jitter_sum   = {1'b0, in_jitter} + {1'b0, dmp_pkg::JITTER_BASE};
  assign jitter_watch = jitter_sum[8] ? 8'hFF : jitter_sum[7:0];
  assign high         = (in_sample > level_threshold);
  assign filter_history_next = {high, filter_history[2:1]};
  assign filt         = dmp_pkg::MAJORITY3[filter_history_next];

  always_comb begin
    mode_next          = mode;
    last_level_next    = last_level;
    run_count_next     = run_count;
    rx_next            = rx;
    rx_a               = rx;
    rx_b               = rx;
    prev_rx_frame_next = prev_rx_frame;
    watch_count_next   = watch_count;
    tx_shift_next      = tx_shift;
    tx_ticks_left_next = tx_ticks_left;
    retry_bits_next    = retry_bits;
    retry_len_next     = retry_len;
    backward_flag_next = backward_flag;
    break_count_next   = break_count;
    retry_count_next   = retry_count;
    drive_level_next   = drive_level;
    ready              = 1'b0;
    valid              = 1'b0;
    repeat_hit         = 1'b0;
    status             = dmp_pkg::STATUS_NONE;
    qfull_flag         = 1'b0;
    start              = 1'b0;
    start_bits         = in_bits & 32'hFF;
    start_len          = 5'd8;
    start_watch        = in_watch;
    start_back         = 1'b1;
    do_pop             = 1'b0;
    qctl               = '0;

    if (in_func == dmp_pkg::FUNC_FORWARD) begin
      if (q_full) begin
        qfull_flag = 1'b1;
      end else begin
        qctl.push = accept;
      end
    end else if (in_func == dmp_pkg::FUNC_BACKWARD) begin
      start = 1'b1;
    end else if (in_func == dmp_pkg::FUNC_TICK) begin
      unique case (mode)
        M_IDLE: begin
          if (!filt) begin
            rx_next   = '0;
            mode_next = M_RECEIVE;
          end else if (q_nonempty && high && (run_count >= idle_before_send)) begin
            start       = 1'b1;
            start_bits  = 32'(q_bits);
            start_len   = q_len;
            start_watch = jitter_watch;
            start_back  = 1'b0;
          end else if (run_count >= repeat_window) begin
            prev_rx_frame_next = '0;
          end
        end
        M_RECEIVE: begin
          rx_a = rx_half(rx, last_level, FMASK);
          rx_b = rx_half(rx_a, last_level, FMASK);
          if (filt != last_level) begin
            if ((run_count >= dmp_pkg::HALF_MIN) && (run_count <= dmp_pkg::HALF_MAX)) begin
              rx_next = rx_a;
            end else if ((run_count >= dmp_pkg::FULL_MIN) &&
                         (run_count <= dmp_pkg::FULL_MAX)) begin
              rx_next = rx_b;
            end else begin
              rx_next.bad = 1'b1;
            end
          end
          if (rx_next.bad) begin
            mode_next = M_INVALID;
          end
          rx_next.bad = 1'b0;
          if (!filt && (run_count >= dmp_pkg::LOW_LIMIT)) begin
            mode_next = M_INVALID;
          end else if (filt && (run_count >= stop_run_length)) begin
            mode_next = M_IDLE;
            ready     = 1'b1;
            valid     = 1'b1;
          end
        end
        M_INVALID: begin
          if (filt && (run_count >= stop_run_length)) begin
            mode_next = M_IDLE;
            ready     = 1'b1;
          end
        end
        M_WATCH: begin
          if (!high && !backward_flag) begin
            mode_next = M_IDLE;
          end else begin
            watch_count_next = watch_count - 8'd1;
            if (watch_count_next == 8'd0) begin
              mode_next = M_SEND;
            end
          end
        end
        M_SEND: begin
          if (!backward_flag && !drive_level && !high) begin
            // Collision: someone else pulled the bus low.
            if (retry_count < dmp_pkg::RETRY_SAT) begin
              retry_count_next = retry_count + 4'd1;
            end
            mode_next        = M_BREAK;
            break_count_next = break_ticks;
            drive_level_next = 1'b1;
          end else begin
            drive_level_next = tx_shift[0] ^ tx_ticks_left[2];
            if (tx_ticks_left == 8'd0) begin
              mode_next        = M_IDLE;
              drive_level_next = 1'b0;
              do_pop           = !backward_flag;
              retry_count_next = '0;
              status           = dmp_pkg::STATUS_SENT;
            end
            if (tx_ticks_left[2:0] == 3'd0) begin
              tx_shift_next = {1'b0, tx_shift[31:1]};
            end
            tx_ticks_left_next = tx_ticks_left - 8'd1;
          end
        end
        M_BREAK: begin
          if (break_count == 8'd0) begin
            drive_level_next = 1'b0;
            if (retry_count < max_retries) begin
              start       = 1'b1;
              start_bits  = retry_bits;
              start_len   = retry_len;
              start_watch = recover_ticks;
              start_back  = 1'b0;
            end else begin
              mode_next        = M_IDLE;
              do_pop           = !backward_flag;
              retry_count_next = '0;
              status           = dmp_pkg::STATUS_DROPPED;
            end
          end
          break_count_next = break_count - 8'd1;
        end
        default: ;
      endcase

      if (filt == last_level) begin
        if (run_count != 8'hFF) begin
          run_count_next = run_count + 8'd1;
        end
      end else begin
        last_level_next = filt;
        run_count_next  = 8'd1;
      end

      if (ready) begin
        repeat_hit         = ({rx_next.count, rx_next.shift} == prev_rx_frame);
        prev_rx_frame_next = {rx_next.count, rx_next.shift};
      end
    end

    if (start) begin
      start_len          = (start_len > dmp_pkg::TX_MAX_LEN) ? dmp_pkg::TX_MAX_LEN
                                                              : start_len;
      retry_bits_next    = start_bits;
      retry_len_next     = start_len;
      tx_shift_next      = tx_pattern(start_bits, start_len);
      tx_ticks_left_next = {start_len, 3'b000} + dmp_pkg::TX_OVERHEAD;
      mode_next          = M_WATCH;
      watch_count_next   = start_watch;
      backward_flag_next = start_back;
    end

    qctl.pop = accept && do_pop && q_nonempty;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      filter_history <= '0;
      last_level     <= 1'b1;
      run_count      <= '0;
      rx             <= '0;
      prev_rx_frame  <= '0;
      watch_count    <= '0;
      tx_shift       <= '0;
      tx_ticks_left  <= '0;
      retry_bits     <= '0;
      retry_len      <= '0;
      backward_flag  <= 1'b0;
      break_count    <= '0;
      retry_count    <= '0;
      drive_level    <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        if (in_func == dmp_pkg::FUNC_TICK) begin
          filter_history <= filter_history_next;
        end
        last_level    <= last_level_next;
        run_count     <= run_count_next;
        rx            <= rx_next;
        prev_rx_frame <= prev_rx_frame_next;
        watch_count   <= watch_count_next;
        tx_shift      <= tx_shift_next;
        tx_ticks_left <= tx_ticks_left_next;
        retry_bits    <= retry_bits_next;
        retry_len     <= retry_len_next;
        backward_flag <= backward_flag_next;
        break_count   <= break_count_next;
        retry_count   <= retry_count_next;
        drive_level   <= drive_level_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {3'b000, qfull_flag, status, repeat_hit, valid,
                       ready ? rx_next.count : 6'd0,
                       ready ? rx_next.shift : 32'd0,
                       ready, drive_level_next};
    end
  end

`ifndef SYNTHESIS
  // A timing-clean frame is always reported as ended.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tdata[1])
    else $error("rx_valid without rx_ready");

  // A break holds the bus low for its whole length.
  assert property (@(posedge clk) disable iff (rst)
    (mode == M_BREAK) |-> drive_level)
    else $error("bus released during break");

  // The queue never holds more frames than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

@@ tb/dali_phy_checker.sv @@
// ----------------------------------------------------------------------------
// DALI PHY scoreboard
// Watches the input, result and register channels of the bus PHY, predicts
// each result word from its own copy of the PHY state and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dali_phy_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [71:0] s_axis_tdata,
  input  wire [1:0]  s_axis_tuser,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [47:0] m_axis_tdata,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire        pready,
  input  wire [4:0]  paddr,
  input  wire [31:0] pwdata,
  output int         fail_count,
  output int         outstanding
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RECEIVE, PH_INVALID, PH_WATCH, PH_SEND, PH_BREAK
  } phase_e;

  typedef struct packed {
    logic        drive;
    logic        ready;
    logic [31:0] frame;
    logic [5:0]  length;
    logic        valid;
    logic        rep_hit;
    logic [1:0]  status;
    logic        qfull;
  } bus_result_t;

  bus_result_t bus_results_q[$];

  // Register copies.
  logic [11:0] thr;
  logic [7:0]  stop_run, idle_send, rep_window, brk_ticks, rec_ticks;
  logic [3:0]  max_retry;

  // PHY state copy.
  logic [2:0]  hist;
  logic        last_lvl;
  phase_e      phase;
  logic [7:0]  run_len;
  logic [31:0] rx_bits;
  logic [5:0]  rx_cnt;
  logic        half_ph;
  logic [37:0] prev_frame;
  logic [7:0]  watch_cnt;
  logic [31:0] tx_bits;
  logic [7:0]  tx_left;
  logic [37:0] retry_fr;
  logic        bwd;
  logic [7:0]  brk_cnt;
  logic [3:0]  retries;
  logic        drive;
  logic [37:0] txq[16];
  int          qhead, qtail, qcount;

  assign outstanding = bus_results_q.size();

  task automatic load_send(input logic [31:0] bits, input logic [5:0] len,
                           input logic [7:0] wt, input logic backward);
    logic [31:0] s;
    s = '0;
    if (len > 6'(dmp_pkg::TX_MAX_LEN)) len = 6'(dmp_pkg::TX_MAX_LEN);
    retry_fr = {len, bits};
    for (int i = 0; i < len; i++) begin
      s = (s | {31'd0, ~bits[0]}) << 1;
      bits = bits >> 1;
    end
    tx_bits = s;
    tx_left = 8'(len * 8 + dmp_pkg::TX_OVERHEAD);
    phase = PH_WATCH;
    watch_cnt = wt;
    bwd = backward;
  endtask

  task automatic drop_head();
    if (qcount != 0) begin
      qhead = (qhead + 1) % 16;
      qcount--;
    end
  endtask

  task automatic half_bit(input logic lvl);
    if (!half_ph) begin
      rx_bits = {rx_bits[30:0], ~lvl};
      if (rx_cnt < dmp_pkg::RX_COUNT_SAT) rx_cnt++;
    end else if (rx_bits[0] != lvl) begin
      phase = PH_INVALID;
    end
    half_ph = ~half_ph;
  endtask

  // One input word through the PHY; returns the result word it yields.
  task automatic phy_step(input logic [1:0] func, input logic [71:0] d,
                          output bus_result_t r);
    logic [11:0] sample;
    logic [7:0]  jit;
    logic [31:0] fbits;
    logic [4:0]  flen;
    logic [7:0]  wticks;
    logic        high, filt;
    logic [8:0]  w;
    logic [37:0] cur;
    sample = d[11:0];
    jit    = d[19:12];
    fbits  = d[51:20];
    flen   = d[56:52];
    wticks = d[64:57];
    r = '0;
    if (func == dmp_pkg::FUNC_FORWARD) begin
      if (qcount >= 16) begin
        r.qfull = 1'b1;
      end else begin
        txq[qtail] = {1'b0, flen, fbits};
        qtail = (qtail + 1) % 16;
        qcount++;
      end
    end else if (func == dmp_pkg::FUNC_BACKWARD) begin
      load_send({24'd0, fbits[7:0]}, 6'd8, wticks, 1'b1);
    end else if (func == dmp_pkg::FUNC_TICK) begin
      high = sample > thr;
      hist = {high, hist[2:1]};
      filt = dmp_pkg::MAJORITY3[hist];
      case (phase)
        PH_IDLE: begin
          if (!filt) begin
            rx_bits = '0;
            rx_cnt = '0;
            half_ph = 1'b0;
            phase = PH_RECEIVE;
          end else if (qcount != 0 && high && run_len >= idle_send) begin
            w = jit + dmp_pkg::JITTER_BASE;
            if (w > 255) w = 255;
            load_send(txq[qhead][31:0], txq[qhead][37:32], w[7:0], 1'b0);
          end else if (run_len >= rep_window) begin
            prev_frame = '0;
          end
        end
        PH_RECEIVE: begin
          if (filt != last_lvl) begin
            if (run_len >= dmp_pkg::HALF_MIN && run_len <= dmp_pkg::HALF_MAX) begin
              half_bit(last_lvl);
            end else if (run_len >= dmp_pkg::FULL_MIN && run_len <= dmp_pkg::FULL_MAX) begin
              half_bit(last_lvl);
              half_bit(last_lvl);
            end else begin
              phase = PH_INVALID;
            end
          end
          if (!filt && run_len >= dmp_pkg::LOW_LIMIT) begin
            phase = PH_INVALID;
          end else if (filt && run_len >= stop_run) begin
            phase = PH_IDLE;
            r.ready = 1'b1;
            r.valid = 1'b1;
          end
        end
        PH_INVALID: begin
          if (filt && run_len >= stop_run) begin
            phase = PH_IDLE;
            r.ready = 1'b1;
          end
        end
        PH_WATCH: begin
          if (!high && !bwd) begin
            phase = PH_IDLE;
          end else begin
            watch_cnt = watch_cnt - 8'd1;
            if (watch_cnt == 0) phase = PH_SEND;
          end
        end
        PH_SEND: begin
          if (!bwd && !drive && !high) begin
            // Someone else pulled the bus low: collision, go drive a break.
            if (retries < dmp_pkg::RETRY_SAT) retries++;
            phase = PH_BREAK;
            brk_cnt = brk_ticks;
            drive = 1'b1;
          end else begin
            drive = tx_bits[0] ^ tx_left[2];
            if (tx_left == 0) begin
              phase = PH_IDLE;
              drive = 1'b0;
              if (!bwd) drop_head();
              retries = '0;
              r.status = dmp_pkg::STATUS_SENT;
            end
            if (tx_left[2:0] == 3'd0) tx_bits = tx_bits >> 1;
            tx_left = tx_left - 8'd1;
          end
        end
        PH_BREAK: begin
          if (brk_cnt == 0) begin
            drive = 1'b0;
            if (retries < max_retry) begin
              load_send(retry_fr[31:0], retry_fr[37:32], rec_ticks, 1'b0);
            end else begin
              phase = PH_IDLE;
              if (!bwd) drop_head();
              retries = '0;
              r.status = dmp_pkg::STATUS_DROPPED;
            end
          end
          brk_cnt = brk_cnt - 8'd1;
        end
        default: ;
      endcase
      if (filt == last_lvl) begin
        if (run_len != 8'd255) run_len++;
      end else begin
        last_lvl = filt;
        run_len = 8'd1;
      end
      if (r.ready) begin
        cur = {rx_cnt, rx_bits};
        r.rep_hit = (cur == prev_frame);
        prev_frame = cur;
        r.frame = rx_bits;
        r.length = rx_cnt;
      end
    end
    r.drive = drive;
  endtask

  task automatic report(input string what, input logic [47:0] exp_v,
                        input logic [47:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("MISMATCH %s: expected %h got %h at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk) begin
    bus_result_t r, e, a;
    if (rst) begin
      bus_results_q.delete();
      fail_count = 0;
      thr = 12'd2048; stop_run = 8'd20; idle_send = 8'd60; rep_window = 8'd255;
      brk_ticks = 8'd12; rec_ticks = 8'd40; max_retry = 4'd3;
      hist = '0; last_lvl = 1'b1; phase = PH_IDLE; run_len = '0;
      rx_bits = '0; rx_cnt = '0; half_ph = 1'b0; prev_frame = '0;
      watch_cnt = '0; tx_bits = '0; tx_left = '0; retry_fr = '0; bwd = 1'b0;
      brk_cnt = '0; retries = '0; drive = 1'b0;
      qhead = 0; qtail = 0; qcount = 0;
    end else begin
      // Results are registered after their input word, so check first.
      if (m_axis_tvalid && m_axis_tready) begin
        a.drive   = m_axis_tdata[0];
        a.ready   = m_axis_tdata[1];
        a.frame   = m_axis_tdata[33:2];
        a.length  = m_axis_tdata[39:34];
        a.valid   = m_axis_tdata[40];
        a.rep_hit = m_axis_tdata[41];
        a.status  = m_axis_tdata[43:42];
        a.qfull   = m_axis_tdata[44];
        if (bus_results_q.size() == 0) begin
          report("unexpected word", '0, m_axis_tdata);
        end else begin
          e = bus_results_q.pop_front();
          if (e.drive != a.drive)     report("tx_drive", e.drive, a.drive);
          if (e.ready != a.ready)     report("rx_ready", e.ready, a.ready);
          if (e.frame != a.frame)     report("rx_frame", e.frame, a.frame);
          if (e.length != a.length)   report("rx_length", e.length, a.length);
          if (e.valid != a.valid)     report("rx_valid", e.valid, a.valid);
          if (e.rep_hit != a.rep_hit) report("rx_repeat", e.rep_hit, a.rep_hit);
          if (e.status != a.status)   report("send_status", e.status, a.status);
          if (e.qfull != a.qfull)     report("queue_full", e.qfull, a.qfull);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        phy_step(s_axis_tuser, s_axis_tdata, r);
        bus_results_q.push_back(r);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          dmp_pkg::REG_THRESHOLD: thr = pwdata[11:0];
          dmp_pkg::REG_STOP_RUN:  stop_run = pwdata[7:0];
          dmp_pkg::REG_IDLE_SEND: idle_send = pwdata[7:0];
          dmp_pkg::REG_REPEAT:    rep_window = pwdata[7:0];
          dmp_pkg::REG_BREAK:     brk_ticks = pwdata[7:0];
          dmp_pkg::REG_RECOVER:   rec_ticks = pwdata[7:0];
          dmp_pkg::REG_RETRIES:   max_retry = pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// DALI PHY testbench
// Drives bus samples and frame commands into the PHY under random handshake
// gaps, walks several register settings, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Command code the PHY ignores.
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = dmp_pkg::FUNC_TICK;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  int          fail_count, outstanding;

  // Mirrors of the registers that shape the stimulus.
  logic [11:0] cur_thr = 12'd2048;
  int          cur_stop = 20, cur_idle = 60, cur_break = 12, cur_recover = 40;

  // When set, neither side idles: back-to-back words on both channels.
  logic calm = 1'b0;
  int   words_sent = 0;
  int   cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dali_manchester_phy_mac dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dali_phy_checker scoreboard (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .outstanding
  );

  // Watchdog: far above the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("dali_manchester_phy_mac verification failed");
      $finish;
    end
  end

  // Result side: each word waits a random stall before it is taken.
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      w = calm ? 0 : $urandom_range(12, 0);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Send one word after a random gap and wait until the PHY takes it.
  task automatic put_word(input logic [1:0] func, input logic [11:0] sample,
                          input logic [7:0] jit, input logic [31:0] bits,
                          input logic [4:0] len, input logic [7:0] watch);
    int gap;
    gap = calm ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {7'd0, watch, len, bits, jit, sample};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (func != FUNC_IGNORED) words_sent++;
  endtask

  // One sample tick at the wanted bus level; unused fields carry noise.
  task automatic tick(input logic lvl);
    logic [11:0] s;
    if (lvl && cur_thr != 12'hFFF) s = 12'($urandom_range(4095, cur_thr + 1));
    else s = 12'($urandom_range(cur_thr, 0));
    put_word(dmp_pkg::FUNC_TICK, s, 8'($urandom), $urandom, 5'($urandom),
             8'($urandom));
  endtask

  task automatic hold(input logic lvl, input int n);
    repeat (n) tick(lvl);
  endtask

  // Half-bit run, mostly nominal; sloppy frames vary it and may break it.
  task automatic half_run(input logic lvl, input bit sloppy);
    int n;
    n = 4;
    if (sloppy) n = ($urandom_range(15, 0) == 0) ? $urandom_range(12, 1)
                                                 : $urandom_range(5, 3);
    hold(lvl, n);
  endtask

  // Manchester frame on the bus: start bit, then n data bits MSB first.
  task automatic bus_frame(input logic [31:0] bits, input int n, input bit sloppy);
    half_run(1'b0, sloppy);
    half_run(1'b1, sloppy);
    for (int i = n - 1; i >= 0; i--) begin
      half_run(~bits[i], sloppy);
      half_run(bits[i], sloppy);
    end
    hold(1'b1, cur_stop + 3);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let every expected word drain, then let the registered result settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [11:0] thr, input int stop, input int idle,
                          input int rep, input int brk, input int rec,
                          input int retr);
    drain();
    write_reg(dmp_pkg::REG_THRESHOLD, thr);
    write_reg(dmp_pkg::REG_STOP_RUN, stop);
    write_reg(dmp_pkg::REG_IDLE_SEND, idle);
    write_reg(dmp_pkg::REG_REPEAT, rep);
    write_reg(dmp_pkg::REG_BREAK, brk);
    write_reg(dmp_pkg::REG_RECOVER, rec);
    write_reg(dmp_pkg::REG_RETRIES, retr);
    cur_thr = thr;
    cur_stop = stop;
    cur_idle = idle;
    cur_break = brk;
    cur_recover = rec;
  endtask

  // One random chunk of bus activity.
  task automatic random_chunk();
    logic [31:0] bits;
    logic [7:0]  jit;
    int          len, n;
    calm = ($urandom_range(3, 0) == 0);
    bits = $urandom;
    case ($urandom_range(9, 0))
      0, 1, 2: bus_frame(bits, $urandom_range(16, 1), $urandom_range(2, 0) == 0);
      3: repeat (20) put_word(dmp_pkg::FUNC_TICK, 12'($urandom), 8'($urandom),
                              $urandom, 5'($urandom), 8'($urandom));
      4, 5: begin
        // Forward frame, then either a clean send or a collision mid-frame.
        len = ($urandom_range(5, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(8, 1);
        jit = ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'($urandom_range(7, 0));
        put_word(dmp_pkg::FUNC_FORWARD, 12'($urandom), 8'($urandom), bits, 5'(len),
                 8'($urandom));
        if ($urandom_range(2, 0) == 0) begin
          hold(1'b1, cur_idle + jit + 12);
          hold(1'b0, 5);
          hold(1'b1, cur_break + cur_recover + 20);
        end else begin
          put_word(dmp_pkg::FUNC_TICK, 12'hFFF, jit, $urandom, 5'($urandom),
                   8'($urandom));
          hold(1'b1, cur_idle + jit + 8 * len + 30);
        end
      end
      6: begin
        n = $urandom_range(20, 1);
        put_word(dmp_pkg::FUNC_BACKWARD, 12'($urandom), 8'($urandom), bits,
                 5'($urandom), 8'(n));
        hold(1'b1, n + 85);
      end
      7: begin
        put_word(FUNC_IGNORED, 12'($urandom), 8'($urandom), $urandom, 5'($urandom),
                 8'($urandom));
        put_word(2'($urandom_range(2, 0)), 12'($urandom), 8'($urandom), $urandom,
                 5'($urandom), 8'($urandom));
      end
      default: begin
        // The same frame twice in a row exercises repeat detection.
        n = $urandom_range(8, 1);
        bus_frame(bits, n, 1'b0);
        bus_frame(bits, n, 1'b0);
      end
    endcase
  endtask

  task automatic random_phase(input int target);
    while (words_sent < target) random_chunk();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sample extremes, an ignored command, a backward frame with a
    // zero watch time (wraps to 256 ticks), oversized and empty forward
    // frames, then enough forward frames to overflow the queue.
    calm = 1'b1;
    put_word(dmp_pkg::FUNC_TICK, 12'h000, 8'h00, 32'h0, 5'd0, 8'h00);
    put_word(dmp_pkg::FUNC_TICK, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 5'd31, 8'hFF);
    put_word(FUNC_IGNORED, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 5'd31, 8'hFF);
    put_word(dmp_pkg::FUNC_BACKWARD, 12'h0, 8'h0, 32'hFFFF_FFFF, 5'd0, 8'h00);
    put_word(dmp_pkg::FUNC_FORWARD, 12'h0, 8'hFF, 32'hFFFF_FFFF, 5'd31, 8'h0);
    put_word(dmp_pkg::FUNC_FORWARD, 12'h0, 8'h00, 32'h0, 5'd0, 8'h0);
    for (int i = 0; i < 15; i++)
      put_word(dmp_pkg::FUNC_FORWARD, 12'h0, 8'h0, $urandom,
               5'($urandom_range(3, 1)), 8'h0);
    put_word(dmp_pkg::FUNC_TICK, 12'hFFF, 8'hFF, 32'h0, 5'd0, 8'h0);
    calm = 1'b0;

    // Random phases over several register settings, extremes included.
    random_phase(300);
    set_regs(12'd2048, 12, 8, 255, 12, 20, 3);
    random_phase(520);
    set_regs(12'd0, 1, 1, 1, 0, 1, 0);
    random_phase(650);
    set_regs(12'hFFF, 255, 255, 200, 255, 255, 15);
    random_phase(700);
    set_regs(12'd1000, 255, 255, 200, 255, 255, 15);
    random_phase(850);
    set_regs(12'd3000, 20, 30, 100, 5, 10, 2);
    random_phase(980);

    drain();
    if (fail_count == 0) begin
      $display("dali_manchester_phy_mac verification clean");
    end else begin
      $display("dali_manchester_phy_mac verification failed");
    end
    $finish;
  end

endmodule
